FILE: rtl/meq_pkg.sv
package meq_pkg;

    localparam int QueueDepth = 20;
    localparam int KeymapBytes = 16;
    localparam int SlotW = $clog2(QueueDepth);
    localparam int CountW = $clog2(QueueDepth + 1);
    localparam int KeyBits = KeymapBytes * 8;
    localparam int EntryW = 4 + 32 + 32 + 32 + 16;

    localparam logic [3:0] AutokeyType = 4'd5;

    typedef enum logic [2:0] {
        OP_POST  = 3'd0,
        OP_GET   = 3'd1,
        OP_PEEK  = 3'd2,
        OP_FLUSH = 3'd3,
        OP_KEY   = 3'd4,
        OP_ARM   = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DISABLED = 2'd1,
        ST_NULL     = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CFG_ENABLE   = 2'd0,
        CFG_DELAY    = 2'd1,
        CFG_INTERVAL = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_SHIFT,
        S_DONE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture inputs
        logic do_post;    // write entry, append
        logic do_key;
        logic do_arm;
        logic drop;       // start removal at scan_pos
        logic shift_step; // one compaction step
        logic advance;    // scan_pos++
        logic hit_out;    // return entry
        logic miss_out;   // return autokey or null
        logic plain_out;  // status only result
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [2:0] op;
        logic       scan_end;    // scan_pos >= count
        logic       match;       // entry type in event mask
        logic       stop;        // entry type in stop mask
        logic       shift_end;   // compaction finished
        logic       enabled;
    } stat_t;

endpackage

FILE: rtl/meq_ram.sv
module meq_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/meq_ctrl.sv
module meq_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  meq_pkg::stat_t st,
    output meq_pkg::cmd_t  cmd
);

    meq_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= meq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        busy = (state_reg != meq_pkg::S_IDLE);
        case (state_reg)
            meq_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    state_next = meq_pkg::S_READ;
                end
            end
            meq_pkg::S_READ:
            begin
                case (st.op)
                    meq_pkg::OP_POST:
                    begin
                        if (st.enabled)
                        begin
                            cmd.do_post = 1'b1;
                        end
                        cmd.plain_out = 1'b1;
                        state_next = meq_pkg::S_DONE;
                    end
                    meq_pkg::OP_GET, meq_pkg::OP_PEEK, meq_pkg::OP_FLUSH:
                    begin
                        if (st.scan_end)
                        begin
                            if (st.op == meq_pkg::OP_FLUSH)
                            begin
                                cmd.plain_out = 1'b1;
                            end
                            else
                            begin
                                cmd.miss_out = 1'b1;
                            end
                            state_next = meq_pkg::S_DONE;
                        end
                        else
                        begin
                            state_next = meq_pkg::S_CHECK;
                        end
                    end
                    meq_pkg::OP_KEY:
                    begin
                        cmd.do_key = 1'b1;
                        cmd.plain_out = 1'b1;
                        state_next = meq_pkg::S_DONE;
                    end
                    meq_pkg::OP_ARM:
                    begin
                        cmd.do_arm = 1'b1;
                        cmd.plain_out = 1'b1;
                        state_next = meq_pkg::S_DONE;
                    end
                    default:
                    begin
                        cmd.plain_out = 1'b1;
                        state_next = meq_pkg::S_DONE;
                    end
                endcase
            end
            meq_pkg::S_CHECK:
            begin
                if (st.op == meq_pkg::OP_FLUSH)
                begin
                    if (st.stop)
                    begin
                        cmd.plain_out = 1'b1;
                        state_next = meq_pkg::S_DONE;
                    end
                    else if (st.match)
                    begin
                        cmd.drop = 1'b1;
                        state_next = meq_pkg::S_SHIFT;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                        state_next = meq_pkg::S_READ;
                    end
                end
                else if (st.match)
                begin
                    cmd.hit_out = 1'b1;
                    if (st.op == meq_pkg::OP_GET)
                    begin
                        cmd.drop = 1'b1;
                        state_next = meq_pkg::S_SHIFT;
                    end
                    else
                    begin
                        state_next = meq_pkg::S_DONE;
                    end
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next = meq_pkg::S_READ;
                end
            end
            meq_pkg::S_SHIFT:
            begin
                if (st.shift_end)
                begin
                    state_next = (st.op == meq_pkg::OP_FLUSH) ? meq_pkg::S_READ
                                                               : meq_pkg::S_DONE;
                end
                else
                begin
                    cmd.shift_step = 1'b1;
                end
            end
            meq_pkg::S_DONE:
            begin
                state_next = meq_pkg::S_IDLE;
            end
            default:
            begin
                state_next = meq_pkg::S_IDLE;
            end
        endcase
    end

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> state_reg == meq_pkg::S_IDLE)
        else $error("load outside idle");
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("start not taken");
    a_one_out: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({cmd.hit_out, cmd.miss_out, cmd.plain_out}) <= 1)
        else $error("multiple results");

endmodule

FILE: rtl/meq_datapath.sv
module meq_datapath (
    input  logic                     clk,
    input  logic                     rst_n,
    input  meq_pkg::cmd_t            cmd,
    output meq_pkg::stat_t           st,
    input  logic                     cfg_valid,
    input  logic [1:0]               cfg_index,
    input  logic [15:0]              cfg_data,
    input  logic [2:0]               operation,
    input  logic [3:0]               event_code,
    input  logic [31:0]              message,
    input  logic [15:0]              event_mask,
    input  logic [15:0]              stop_mask,
    input  logic [7:0]               key_code,
    input  logic                     key_down,
    input  logic                     button_state,
    input  logic [31:0]              now,
    input  logic signed [15:0]       mouse_h,
    input  logic signed [15:0]       mouse_v,
    output logic                     done,
    output logic [1:0]               status,
    output logic [3:0]               event_type,
    output logic [31:0]              event_message,
    output logic [31:0]              event_time,
    output logic signed [15:0]       event_h,
    output logic signed [15:0]       event_v,
    output logic [15:0]              event_modifiers
);

    localparam int SW = meq_pkg::SlotW;
    localparam int CW = meq_pkg::CountW;
    localparam int EW = meq_pkg::EntryW;

    logic [15:0] enable_reg, delay_reg, interval_reg;
    logic [2:0]  op_reg;
    logic [3:0]  code_reg;
    logic [31:0] msg_reg, now_reg;
    logic [15:0] emask_reg, smask_reg, h_reg, v_reg;
    logic [7:0]  kcode_reg;
    logic        kdown_reg, btn_reg;

    logic [meq_pkg::KeyBits-1:0] keys_reg;
    logic        armed_reg;
    logic [31:0] rmsg_reg, deadline_reg;

    // arrival order: slot index per position, read at the scan position and at the head
    logic [SW-1:0] order_reg [meq_pkg::QueueDepth];
    logic [meq_pkg::QueueDepth-1:0] used_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] pos_reg;
    logic [CW-1:0] shp_reg;
    logic          shifting_reg;

    logic          done_reg;
    logic [1:0]    status_reg;
    logic [3:0]    type_reg;
    logic [31:0]   omsg_reg, otime_reg;
    logic [15:0]   oh_reg, ov_reg, omod_reg;

    logic [EW-1:0] rdata, wdata;
    logic [SW-1:0] raddr, free_slot, waddr, drop_slot;
    logic [15:0]   mods;
    logic          full;

    function automatic logic key_dn(input logic [meq_pkg::KeyBits-1:0] k,
                                    input int c);
        if (c < meq_pkg::KeyBits)
        begin
            return k[c];
        end
        return 1'b0;
    endfunction

    always_comb
    begin
        mods = '0;
        mods[7]  = btn_reg;
        mods[8]  = key_dn(keys_reg, 'h37);
        mods[9]  = key_dn(keys_reg, 'h38) | key_dn(keys_reg, 'h3C);
        mods[11] = key_dn(keys_reg, 'h3A) | key_dn(keys_reg, 'h3D);
        mods[12] = key_dn(keys_reg, 'h3B) | key_dn(keys_reg, 'h3E);
    end

    always_comb
    begin
        free_slot = '0;
        for (int i = meq_pkg::QueueDepth - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_slot = SW'(i);
            end
        end
    end

    assign full = (count_reg >= CW'(meq_pkg::QueueDepth));
    // when full, the oldest slot is dropped and reused
    assign waddr = full ? order_reg[0] : free_slot;
    assign raddr = order_reg[pos_reg[SW-1:0]];
    assign wdata = {code_reg, msg_reg, now_reg, v_reg, h_reg, mods};

    meq_ram #(.Width(EW), .Depth(meq_pkg::QueueDepth)) u_ram (
        .clk  (clk),
        .we   (cmd.do_post),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    logic [3:0] rtype;
    assign rtype = rdata[EW-1 -: 4];
    assign drop_slot = order_reg[pos_reg[SW-1:0]];

    assign st.op        = op_reg;
    assign st.scan_end  = (pos_reg >= count_reg);
    assign st.match     = emask_reg[rtype];
    assign st.stop      = smask_reg[rtype];
    assign st.shift_end = !shifting_reg;
    assign st.enabled   = enable_reg[code_reg];

    logic autokey;
    assign autokey = emask_reg[meq_pkg::AutokeyType] && armed_reg
                     && (now_reg > deadline_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg   <= 16'hFFEF;
            delay_reg    <= 16'd24;
            interval_reg <= 16'd6;
            keys_reg     <= '0;
            armed_reg    <= 1'b0;
            rmsg_reg     <= '0;
            deadline_reg <= '0;
            used_reg     <= '0;
            count_reg    <= '0;
            pos_reg      <= '0;
            shp_reg      <= '0;
            shifting_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.hit_out | cmd.miss_out | cmd.plain_out;
            if (cfg_valid)
            begin
                case (cfg_index)
                    meq_pkg::CFG_ENABLE:   enable_reg   <= cfg_data;
                    meq_pkg::CFG_DELAY:    delay_reg    <= cfg_data;
                    meq_pkg::CFG_INTERVAL: interval_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.load)
            begin
                pos_reg <= '0;
            end
            if (cmd.advance)
            begin
                pos_reg <= pos_reg + 1'b1;
            end
            if (cmd.do_key && (int'(kcode_reg) < meq_pkg::KeyBits))
            begin
                keys_reg[kcode_reg[$clog2(meq_pkg::KeyBits)-1:0]] <= kdown_reg;
            end
            if (cmd.do_arm)
            begin
                armed_reg    <= 1'b1;
                rmsg_reg     <= msg_reg;
                deadline_reg <= now_reg + {16'd0, delay_reg};
            end
            if (cmd.miss_out && autokey)
            begin
                deadline_reg <= now_reg + {16'd0, interval_reg};
            end
            if (cmd.do_post)
            begin
                used_reg[waddr] <= 1'b1;
                if (full)
                begin
                    for (int i = 0; i < meq_pkg::QueueDepth - 1; i++)
                    begin
                        order_reg[i] <= order_reg[i + 1];
                    end
                    order_reg[meq_pkg::QueueDepth - 1] <= waddr;
                end
                else
                begin
                    order_reg[count_reg[SW-1:0]] <= waddr;
                    count_reg <= count_reg + 1'b1;
                end
            end
            if (cmd.drop)
            begin
                used_reg[drop_slot] <= 1'b0;
                shp_reg      <= pos_reg;
                shifting_reg <= 1'b1;
            end
            if (cmd.shift_step)
            begin
                if (shp_reg + 1'b1 < count_reg)
                begin
                    order_reg[shp_reg[SW-1:0]] <= order_reg[SW'(shp_reg + 1'b1)];
                    shp_reg <= shp_reg + 1'b1;
                end
                else
                begin
                    count_reg    <= count_reg - 1'b1;
                    shifting_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= operation;
            code_reg  <= event_code;
            msg_reg   <= message;
            emask_reg <= event_mask;
            smask_reg <= stop_mask;
            kcode_reg <= key_code;
            kdown_reg <= key_down;
            btn_reg   <= button_state;
            now_reg   <= now;
            h_reg     <= mouse_h;
            v_reg     <= mouse_v;
        end
        if (cmd.plain_out)
        begin
            status_reg <= (op_reg == meq_pkg::OP_POST && !enable_reg[code_reg])
                          ? meq_pkg::ST_DISABLED : meq_pkg::ST_OK;
            type_reg <= '0;
            omsg_reg <= '0;
            otime_reg <= '0;
            oh_reg <= '0;
            ov_reg <= '0;
            omod_reg <= '0;
        end
        if (cmd.hit_out)
        begin
            status_reg <= meq_pkg::ST_OK;
            {type_reg, omsg_reg, otime_reg, ov_reg, oh_reg, omod_reg} <= rdata;
        end
        if (cmd.miss_out)
        begin
            status_reg <= autokey ? meq_pkg::ST_OK : meq_pkg::ST_NULL;
            type_reg   <= autokey ? meq_pkg::AutokeyType : 4'd0;
            omsg_reg   <= autokey ? rmsg_reg : 32'd0;
            otime_reg  <= now_reg;
            oh_reg     <= h_reg;
            ov_reg     <= v_reg;
            omod_reg   <= mods;
        end
    end

    assign done            = done_reg;
    assign status          = status_reg;
    assign event_type      = type_reg;
    assign event_message   = omsg_reg;
    assign event_time      = otime_reg;
    assign event_h         = oh_reg;
    assign event_v         = ov_reg;
    assign event_modifiers = omod_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(meq_pkg::QueueDepth))
        else $error("count overflow");
    a_used_count: assert property (@(posedge clk) disable iff (!rst_n)
        !shifting_reg |-> $countones(used_reg) == int'(count_reg))
        else $error("slot bookkeeping mismatch");
    a_post_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.do_post && !full) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("post lost");

endmodule

FILE: rtl/masked_event_queue.sv
// Sequence: post, key change, arm and unused ops answer from READ, and done is registered from it.
// Get, peek and flush pass READ and CHECK for each scanned entry (one registered RAM read each), and
// each removal adds a compaction pass in SHIFT. One item is handled at a time; busy stays high
// through compaction.
// Reset (rst_n, async low) empties the queue, clears keys and repeat, restores registers;
// the result strobe done lasts one cycle and the receiver cannot stall.
module masked_event_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic [2:0]         operation,
    input  logic [3:0]         event_code,
    input  logic [31:0]        message,
    input  logic [15:0]        event_mask,
    input  logic [15:0]        stop_mask,
    input  logic [7:0]         key_code,
    input  logic               key_down,
    input  logic               button_state,
    input  logic [31:0]        now,
    input  logic signed [15:0] mouse_h,
    input  logic signed [15:0] mouse_v,
    output logic               done,
    output logic [1:0]         status,
    output logic [3:0]         event_type,
    output logic [31:0]        event_message,
    output logic [31:0]        event_time,
    output logic signed [15:0] event_h,
    output logic signed [15:0] event_v,
    output logic [15:0]        event_modifiers
);

    meq_pkg::cmd_t  cmd;
    meq_pkg::stat_t st;

    assign cfg_ready = 1'b1;

    meq_ctrl u_ctrl (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .busy (busy),
        .st   (st),
        .cmd  (cmd)
    );

    meq_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .st             (st),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .operation      (operation),
        .event_code     (event_code),
        .message        (message),
        .event_mask     (event_mask),
        .stop_mask      (stop_mask),
        .key_code       (key_code),
        .key_down       (key_down),
        .button_state   (button_state),
        .now            (now),
        .mouse_h        (mouse_h),
        .mouse_v        (mouse_v),
        .done           (done),
        .status         (status),
        .event_type     (event_type),
        .event_message  (event_message),
        .event_time     (event_time),
        .event_h        (event_h),
        .event_v        (event_v),
        .event_modifiers(event_modifiers)
    );

endmodule

FILE: tb/masked_event_queue_tb.sv
`timescale 1ns / 1ps

module masked_event_queue_tb;

    typedef struct {
        meq_pkg::op_t op;
        logic [3:0]  code;
        logic [31:0] msg;
        logic [15:0] emask;
        logic [15:0] smask;
        logic [7:0]  kcode;
        logic        kdown;
        logic        button;
        logic [31:0] now;
        logic [15:0] mh;
        logic [15:0] mv;
    } item_t;

    typedef struct {
        meq_pkg::status_t st;
        logic [3:0]  etype;
        logic [31:0] msg;
        logic [31:0] tstamp;
        logic [15:0] h;
        logic [15:0] v;
        logic [15:0] mods;
    } event_rec_t;

    typedef struct {
        logic [3:0]  etype;
        logic [31:0] msg;
        logic [31:0] tstamp;
        logic [15:0] h;
        logic [15:0] v;
        logic [15:0] mods;
    } entry_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic cfg_valid;
    logic cfg_ready;
    logic [1:0] cfg_index;
    logic [15:0] cfg_data;
    logic [2:0] operation;
    logic [3:0] event_code;
    logic [31:0] message;
    logic [15:0] event_mask;
    logic [15:0] stop_mask;
    logic [7:0] key_code;
    logic key_down;
    logic button_state;
    logic [31:0] now;
    logic signed [15:0] mouse_h;
    logic signed [15:0] mouse_v;
    logic done;
    logic [1:0] status;
    logic [3:0] event_type;
    logic [31:0] event_message;
    logic [31:0] event_time;
    logic signed [15:0] event_h;
    logic signed [15:0] event_v;
    logic [15:0] event_modifiers;

    masked_event_queue i_dut (.*);

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // predictor state
    logic [15:0] enable_mask_q;
    logic [15:0] rpt_delay_q;
    logic [15:0] rpt_interval_q;
    entry_t      event_fifo[$];
    logic [meq_pkg::KeyBits-1:0] keys_q;
    logic        rpt_armed_q;
    logic [31:0] rpt_msg_q;
    logic [31:0] rpt_deadline_q;

    item_t      pending_items[$];
    event_rec_t expected_events[$];
    int errors = 0;
    int results_seen = 0;
    int sender_idle_pct = 0;
    longint cycle_count = 0;
    bit driver_hold = 0;

    function automatic logic [15:0] mods_now(logic button);
        logic [15:0] m;
        m = '0;
        m[7] = button;
        m[8] = keys_q[7'h37];
        m[9] = keys_q[7'h38] | keys_q[7'h3C];
        m[11] = keys_q[7'h3A] | keys_q[7'h3D];
        m[12] = keys_q[7'h3B] | keys_q[7'h3E];
        return m;
    endfunction

    function automatic event_rec_t apply_event_op(item_t it);
        event_rec_t r;
        entry_t e;
        int k;
        bit found;
        r = '{meq_pkg::ST_OK, 4'd0, 32'd0, 32'd0, 16'd0, 16'd0, 16'd0};
        found = 0;
        case (it.op)
            meq_pkg::OP_POST:
            begin
                if (!enable_mask_q[it.code])
                    r.st = meq_pkg::ST_DISABLED;
                else
                begin
                    if (event_fifo.size() >= meq_pkg::QueueDepth)
                        void'(event_fifo.pop_front());
                    e = '{it.code, it.msg, it.now, it.mh, it.mv, mods_now(it.button)};
                    event_fifo.push_back(e);
                end
            end
            meq_pkg::OP_GET, meq_pkg::OP_PEEK:
            begin
                for (k = 0; k < event_fifo.size() && !found; k++)
                begin
                    if (it.emask[event_fifo[k].etype])
                    begin
                        e = event_fifo[k];
                        r = '{meq_pkg::ST_OK, e.etype, e.msg, e.tstamp, e.h, e.v, e.mods};
                        if (it.op == meq_pkg::OP_GET)
                            event_fifo.delete(k);
                        found = 1;
                    end
                end
                if (!found)
                begin
                    r.tstamp = it.now;
                    r.h = it.mh;
                    r.v = it.mv;
                    r.mods = mods_now(it.button);
                    if (it.emask[meq_pkg::AutokeyType] && rpt_armed_q
                        && it.now > rpt_deadline_q)
                    begin
                        rpt_deadline_q = it.now + rpt_interval_q;
                        r.etype = meq_pkg::AutokeyType;
                        r.msg = rpt_msg_q;
                    end
                    else
                        r.st = meq_pkg::ST_NULL;
                end
            end
            meq_pkg::OP_FLUSH:
            begin
                k = 0;
                while (k < event_fifo.size())
                begin
                    if (it.smask[event_fifo[k].etype])
                        break;
                    if (it.emask[event_fifo[k].etype])
                        event_fifo.delete(k);
                    else
                        k++;
                end
            end
            meq_pkg::OP_KEY:
            begin
                if (it.kcode < meq_pkg::KeyBits)
                    keys_q[it.kcode[6:0]] = it.kdown;
            end
            meq_pkg::OP_ARM:
            begin
                rpt_armed_q = 1;
                rpt_msg_q = it.msg;
                rpt_deadline_q = it.now + rpt_delay_q;
            end
            default:
                ;
        endcase
        return r;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                expected_events.push_back(apply_event_op(pending_items.pop_front()));
            end
            if (!(start && busy))
            begin
                if (pending_items.size() > 0 && !driver_hold
                    && $urandom_range(99) >= sender_idle_pct)
                begin
                    item_t it;
                    it = pending_items[0];
                    start <= 1'b1;
                    operation <= it.op;
                    event_code <= it.code;
                    message <= it.msg;
                    event_mask <= it.emask;
                    stop_mask <= it.smask;
                    key_code <= it.kcode;
                    key_down <= it.kdown;
                    button_state <= it.button;
                    now <= it.now;
                    mouse_h <= it.mh;
                    mouse_v <= it.mv;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (rst_n && done)
        begin
            event_rec_t x;
            results_seen <= results_seen + 1;
            if (expected_events.size() == 0)
            begin
                $display("%0t: unexpected result status=%0d", $time, status);
                errors <= errors + 1;
            end
            else
            begin
                x = expected_events.pop_front();
                if ({x.st, x.etype, x.msg, x.tstamp, x.h, x.v, x.mods} !==
                    {status, event_type, event_message, event_time, event_h, event_v,
                     event_modifiers})
                begin
                    $display("%0t: mismatch exp st=%0d ty=%0d msg=%h t=%h h=%h v=%h m=%h",
                             $time, x.st, x.etype, x.msg, x.tstamp, x.h, x.v, x.mods);
                    $display("%0t:          got st=%0d ty=%0d msg=%h t=%h h=%h v=%h m=%h",
                             $time, status, event_type, event_message, event_time,
                             event_h, event_v, event_modifiers);
                    errors <= errors + 1;
                end
            end
        end
        if (cycle_count > 2000000)
        begin
            $display("[masked_event_queue] ERROR");
            $finish;
        end
    end

    function automatic item_t rand_item(int op);
        item_t it;
        int r;
        it.op = meq_pkg::op_t'(op);
        it.code = 4'($urandom_range(15));
        it.msg = $urandom;
        r = $urandom_range(3);
        it.emask = (r == 0) ? 16'hFFFF : (r == 1) ? 16'h0020 : 16'($urandom);
        r = $urandom_range(3);
        it.smask = (r == 0) ? 16'h0000 : (r == 1) ? (16'h1 << $urandom_range(15))
                                                  : 16'($urandom);
        r = $urandom_range(3);
        it.kcode = (r == 0) ? 8'($urandom) : 8'(8'h37 + $urandom_range(7));
        it.kdown = 1'($urandom);
        it.button = 1'($urandom);
        it.now = ($urandom_range(9) == 0) ? $urandom : 32'(1000 + $urandom_range(300));
        it.mh = 16'($urandom);
        it.mv = 16'($urandom);
        return it;
    endfunction

    task automatic wait_idle();
        while (pending_items.size() != 0 || expected_events.size() != 0 || start || busy)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_reg(meq_pkg::cfg_idx_t idx, logic [15:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            meq_pkg::CFG_ENABLE: enable_mask_q = val;
            meq_pkg::CFG_DELAY: rpt_delay_q = val;
            default: rpt_interval_q = val;
        endcase
    endtask

    task automatic random_phase(int n);
        int i;
        int j;
        int kind;
        for (i = 0; i < n; i++)
        begin
            kind = $urandom_range(99);
            if (kind < 35)
                pending_items.push_back(rand_item(meq_pkg::OP_POST));
            else if (kind < 55)
                pending_items.push_back(rand_item(meq_pkg::OP_GET));
            else if (kind < 65)
                pending_items.push_back(rand_item(meq_pkg::OP_PEEK));
            else if (kind < 72)
                pending_items.push_back(rand_item(meq_pkg::OP_FLUSH));
            else if (kind < 85)
                pending_items.push_back(rand_item(meq_pkg::OP_KEY));
            else if (kind < 92)
                pending_items.push_back(rand_item(meq_pkg::OP_ARM));
            else if (kind < 95)
                pending_items.push_back(rand_item($urandom_range(6, 7)));
            else
            begin
                // burst of posts to wrap the queue
                for (j = 0; j < 22; j++)
                    pending_items.push_back(rand_item(meq_pkg::OP_POST));
                i += 21;
            end
        end
    endtask

    initial
    begin
        item_t it;
        rst_n = 1'b0;
        start = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = meq_pkg::CFG_ENABLE;
        cfg_data = '0;
        operation = meq_pkg::OP_POST;
        event_code = '0;
        message = '0;
        event_mask = '0;
        stop_mask = '0;
        key_code = '0;
        key_down = 1'b0;
        button_state = 1'b0;
        now = '0;
        mouse_h = '0;
        mouse_v = '0;
        enable_mask_q = 16'hFFEF;
        rpt_delay_q = 16'd24;
        rpt_interval_q = 16'd6;
        keys_q = '0;
        rpt_armed_q = 0;
        rpt_msg_q = '0;
        rpt_deadline_q = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        sender_idle_pct = 7;

        // directed
        it = rand_item(meq_pkg::OP_GET);
        it.emask = 16'hFFFF;
        pending_items.push_back(it);
        it = rand_item(meq_pkg::OP_POST);
        it.code = 4'd4;
        pending_items.push_back(it);
        it = rand_item(meq_pkg::OP_KEY);
        it.kcode = 8'h37;
        it.kdown = 1;
        pending_items.push_back(it);
        it.kcode = 8'hFF;
        pending_items.push_back(it);
        it.kcode = 8'h3E;
        pending_items.push_back(it);
        it = rand_item(meq_pkg::OP_POST);
        it.code = 4'd15;
        it.msg = 32'hFFFFFFFF;
        it.mh = 16'h8000;
        it.mv = 16'h7FFF;
        it.now = 32'hFFFFFFFF;
        it.button = 1;
        pending_items.push_back(it);
        it.code = 4'd0;
        it.msg = 0;
        it.mh = 16'h7FFF;
        it.mv = 16'h8000;
        it.now = 0;
        it.button = 0;
        pending_items.push_back(it);
        it = rand_item(meq_pkg::OP_PEEK);
        it.emask = 16'h8000;
        pending_items.push_back(it);
        it = rand_item(meq_pkg::OP_FLUSH);
        it.emask = 16'hFFFF;
        it.smask = 16'h0001;
        pending_items.push_back(it);
        it = rand_item(meq_pkg::OP_ARM);
        it.now = 32'hFFFFFFF0;
        pending_items.push_back(it);
        it = rand_item(meq_pkg::OP_GET);
        it.emask = 16'h0020;
        it.now = 32'hFFFFFFF5;
        pending_items.push_back(it);
        it.now = 32'h00000010;
        pending_items.push_back(it);
        it.now = 32'h00000020;
        pending_items.push_back(it);
        it = rand_item(6);
        pending_items.push_back(it);
        it = rand_item(7);
        pending_items.push_back(it);
        it = rand_item(meq_pkg::OP_FLUSH);
        it.emask = 16'hFFFF;
        it.smask = 16'h0000;
        pending_items.push_back(it);
        wait_idle();

        write_reg(meq_pkg::CFG_ENABLE, 16'hFFFF);
        write_reg(meq_pkg::CFG_DELAY, 16'd0);
        write_reg(meq_pkg::CFG_INTERVAL, 16'd0);
        random_phase(450);
        // pause mid-phase until every result is back
        while (pending_items.size() > 225)
            @(posedge clk);
        driver_hold = 1;
        while (expected_events.size() != 0 || start || busy)
            @(posedge clk);
        driver_hold = 0;
        wait_idle();

        write_reg(meq_pkg::CFG_ENABLE, 16'h0000);
        write_reg(meq_pkg::CFG_DELAY, 16'hFFFF);
        write_reg(meq_pkg::CFG_INTERVAL, 16'hFFFF);
        sender_idle_pct = 66;
        random_phase(60);
        wait_idle();

        write_reg(meq_pkg::CFG_ENABLE, 16'h5AFF);
        write_reg(meq_pkg::CFG_DELAY, 16'd30);
        write_reg(meq_pkg::CFG_INTERVAL, 16'd5);
        random_phase(390);
        wait_idle();

        write_reg(meq_pkg::CFG_ENABLE, 16'($urandom));
        write_reg(meq_pkg::CFG_DELAY, 16'($urandom_range(40)));
        write_reg(meq_pkg::CFG_INTERVAL, 16'($urandom_range(20)));
        sender_idle_pct = 0;
        random_phase(430);
        wait_idle();

        $display("Covered post/get/peek/flush/key/arm/unused ops, queue wrap, key repeat,");
        $display("  four register settings; %0d results checked.", results_seen);
        if (errors == 0)
            $display("[masked_event_queue] OK");
        else
            $display("[masked_event_queue] ERROR");
        $finish;
    end

endmodule
